/* sv/pkf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pkf_pkg;

    localparam int QBITS = 33;
    localparam logic [31:0] KONE = 32'h0010_0000;
    localparam logic signed [47:0] SAT_HI = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_LO = 48'shFFFF_8000_0000;

    localparam logic [2:0] CFG_ENABLES = 3'd0;
    localparam logic [2:0] CFG_WINDOWS = 3'd1;
    localparam logic [2:0] CFG_FOLD    = 3'd2;
    localparam logic [2:0] CFG_BOXFOLD = 3'd3;
    localparam logic [2:0] CFG_BOXSIZE = 3'd4;
    localparam logic [2:0] CFG_DEPARAM = 3'd5;
    localparam logic [2:0] CFG_OFFSET  = 3'd6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [31:0]        deriv_in;
        logic [7:0]         iteration;
    } in_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic [31:0]        deriv_out;
        logic [15:0]        pseudo_de;
        logic               saturated;
    } out_t;

    // point in flight: coordinates, derivative, iteration and sticky flag
    typedef struct packed {
        logic [2:0][31:0] c;
        logic [31:0]      de;
        logic [7:0]       it;
        logic             sat;
    } pt_t;

    typedef struct packed {
        logic [63:0]       rem;
        logic [63:0]       den;
        logic [QBITS-1:0]  quo;
        logic              kmax;
        pt_t               pt;
    } div_stage_t;

    // saturate to signed 32 bit, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [47:0] v);
        logic [32:0] r;
        if (v > SAT_HI) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < SAT_LO) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    function automatic logic signed [47:0] sx48(input logic [31:0] v);
        return $signed({{16{v[31]}}, v});
    endfunction

endpackage
`default_nettype wire

/* sv/pkf_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module pkf_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                in_valid,
    input  wire pkf_pkg::div_stage_t in_stage,
    output logic                     out_valid,
    output pkf_pkg::div_stage_t      out_stage
);

    pkf_pkg::div_stage_t stg_reg [pkf_pkg::QBITS];
    logic                vld_reg [pkf_pkg::QBITS];

    for (genvar s = 0; s < pkf_pkg::QBITS; s++) begin : g_stg
        localparam int J = pkf_pkg::QBITS - 1 - s;
        pkf_pkg::div_stage_t src;
        pkf_pkg::div_stage_t stg_next;
        logic                src_v;

        if (s == 0) begin : g_first
            assign src   = in_stage;
            assign src_v = in_valid;
        end else begin : g_rest
            assign src   = stg_reg[s-1];
            assign src_v = vld_reg[s-1];
        end

        // one quotient bit: trial subtract of the shifted divisor
        always_comb begin
            logic [63+pkf_pkg::QBITS:0] sh;
            logic [63+pkf_pkg::QBITS:0] rm;
            logic [63+pkf_pkg::QBITS:0] df;
            sh = {{pkf_pkg::QBITS{1'b0}}, src.den} << J;
            rm = {{pkf_pkg::QBITS{1'b0}}, src.rem};
            df = rm - sh;
            stg_next = src;
            if (rm >= sh) begin
                stg_next.rem    = df[63:0];
                stg_next.quo[J] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= src_v;
            end
            if (en) begin
                stg_reg[s] <= stg_next;
            end
        end
    end

    assign out_valid = vld_reg[pkf_pkg::QBITS-1];
    assign out_stage = stg_reg[pkf_pkg::QBITS-1];

endmodule
`default_nettype wire

/* sv/pseudo_kleinian_fold_step.sv */
// One pseudo-Kleinian fold iteration per word: optional abs fold and box fold,
// clamp and reflect, inversion by k = max(minR2/r2, 1), derivative update and
// final offset, all in Q12.20 with saturation reported in the saturated bit.
// A new word is taken every cycle unless the output word waits. Six stages of
// folds, squares, radius sum and divider set-up, 33 restoring divider stages
// (one quotient bit per stage), a multiply and an output stage. Configuration words
// are always taken and must only be written while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none
module pseudo_kleinian_fold_step (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire pkf_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output pkf_pkg::out_t      m_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [47:0]   cfg_data
);

    // configuration registers
    logic [2:0]  en_reg;
    logic [31:0] win_reg;
    logic [47:0] fold_reg;
    logic [47:0] boxl_reg;
    logic [47:0] boxs_reg;
    logic [47:0] dep_reg;
    logic [47:0] off_reg;
    logic [27:0] zlim_reg;
    logic [27:0] zval_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg   <= '0;
            win_reg  <= '0;
            fold_reg <= '0;
            boxl_reg <= '0;
            boxs_reg <= '0;
            dep_reg  <= '0;
            off_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                pkf_pkg::CFG_ENABLES: en_reg   <= cfg_data[2:0];
                pkf_pkg::CFG_WINDOWS: win_reg  <= cfg_data[31:0];
                pkf_pkg::CFG_FOLD:    fold_reg <= cfg_data;
                pkf_pkg::CFG_BOXFOLD: boxl_reg <= cfg_data;
                pkf_pkg::CFG_BOXSIZE: boxs_reg <= cfg_data;
                pkf_pkg::CFG_DEPARAM: dep_reg  <= cfg_data;
                pkf_pkg::CFG_OFFSET:  off_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // scaled z limit and value of the box fold, settled well before use
    logic [31:0] zlim_full;
    logic [31:0] zval_full;
    assign zlim_full = boxl_reg[15:0] * boxl_reg[47:32];
    assign zval_full = boxl_reg[31:16] * boxl_reg[47:32];
    always_ff @(posedge aclk) begin
        zlim_reg <= zlim_full[31:4];
        zval_reg <= zval_full[31:4];
    end

    // the whole pipe moves together; it holds only while the output word waits
    logic adv;
    assign adv     = !(m_valid && !m_ready);
    assign s_ready = adv;

    logic                v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, vp_reg, vo_reg;
    pkf_pkg::pt_t        p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    pkf_pkg::pt_t        p1_next, p2_next, p3_next;
    logic [2:0][63:0]    sq_reg;
    logic [2:0][63:0]    sq_next;
    logic [63:0]         r2_reg;
    pkf_pkg::div_stage_t dv_reg;
    pkf_pkg::div_stage_t dv_next;
    pkf_pkg::div_stage_t dq;
    logic                dq_v;
    pkf_pkg::pt_t        pp_reg;
    logic [2:0][63:0]    pr_reg;
    logic [64:0]         dm_reg;
    pkf_pkg::pt_t        pp_next;
    logic [2:0][63:0]    pr_next;
    logic [64:0]         dm_next;
    pkf_pkg::out_t       out_reg;
    pkf_pkg::out_t       out_next;

    // stage 1: abs fold
    always_comb begin
        logic                fa;
        logic signed [47:0]  a, pe, s, d, as_, ad, r;
        logic [32:0]         sr;
        fa = en_reg[0] && (s_data.iteration >= win_reg[7:0])
                       && (s_data.iteration < win_reg[15:8]);
        p1_next.c[0] = s_data.pos_x;
        p1_next.c[1] = s_data.pos_y;
        p1_next.c[2] = s_data.pos_z;
        p1_next.de   = s_data.deriv_in;
        p1_next.it   = s_data.iteration;
        p1_next.sat  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a   = $signed({24'd0, fold_reg[16*i +: 16], 8'd0});
            pe  = pkf_pkg::sx48(p1_next.c[i]);
            s   = pe + a;
            d   = pe - a;
            as_ = (s < 0) ? -s : s;
            ad  = (d < 0) ? -d : d;
            r   = as_ - ad - pe;
            sr  = pkf_pkg::sat32(r);
            if (fa && (i < 2 || en_reg[1])) begin
                p1_next.c[i] = sr[31:0];
                p1_next.sat  = p1_next.sat | sr[32];
            end
        end
    end

    // stage 2: box fold, z limit and value scaled
    always_comb begin
        logic                fb;
        logic signed [47:0]  lim, val, v, av, r;
        logic [32:0]         sr;
        fb = en_reg[2] && (p1_reg.it >= win_reg[23:16]) && (p1_reg.it < win_reg[31:24]);
        p2_next = p1_reg;
        for (int i = 0; i < 3; i++) begin
            if (i == 2) begin
                lim = $signed({20'd0, zlim_reg});
                val = $signed({20'd0, zval_reg});
            end else begin
                lim = $signed({24'd0, boxl_reg[15:0], 8'd0});
                val = $signed({24'd0, boxl_reg[31:16], 8'd0});
            end
            v  = pkf_pkg::sx48(p1_reg.c[i]);
            av = (v < 0) ? -v : v;
            r  = (v > 0) ? (val - v) : (-val - v);
            sr = pkf_pkg::sat32(r);
            if (fb && av > lim) begin
                p2_next.c[i] = sr[31:0];
                p2_next.sat  = p2_next.sat | sr[32];
            end
        end
    end

    // stage 3: clamp to the box and reflect
    always_comb begin
        logic signed [47:0]  c, v, t;
        logic [32:0]         sr;
        p3_next = p2_reg;
        for (int i = 0; i < 3; i++) begin
            c = $signed({24'd0, boxs_reg[16*i +: 16], 8'd0});
            v = pkf_pkg::sx48(p2_reg.c[i]);
            t = v;
            if (t > c) begin
                t = c;
            end
            if (t < -c) begin
                t = -c;
            end
            sr = pkf_pkg::sat32((t <<< 1) - v);
            p3_next.c[i] = sr[31:0];
            p3_next.sat  = p3_next.sat | sr[32];
        end
    end

    // stage 4: squares
    always_comb begin
        logic signed [47:0] v, av;
        logic [31:0]        a;
        for (int i = 0; i < 3; i++) begin
            v  = pkf_pkg::sx48(p3_reg.c[i]);
            av = (v < 0) ? -v : v;
            a  = av[31:0];
            sq_next[i] = a * a;
        end
    end

    // stage 6: divider set-up, zero radius and quotient overflow found here
    always_comb begin
        logic [63+pkf_pkg::QBITS:0] nw, dw;
        dv_next.rem  = {dep_reg[15:0], 48'd0};
        dv_next.den  = r2_reg;
        dv_next.quo  = '0;
        nw           = {{pkf_pkg::QBITS{1'b0}}, dv_next.rem};
        dw           = {r2_reg, {pkf_pkg::QBITS{1'b0}}};
        dv_next.kmax = (r2_reg == 64'd0) || (nw >= dw);
        dv_next.pt   = p5_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            vp_reg <= dq_v;
            vo_reg <= vp_reg;
        end
        if (adv) begin
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            p3_reg  <= p3_next;
            p4_reg  <= p3_reg;
            sq_reg  <= sq_next;
            p5_reg  <= p4_reg;
            r2_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            dv_reg  <= dv_next;
            pp_reg  <= pp_next;
            pr_reg  <= pr_next;
            dm_reg  <= dm_next;
            out_reg <= out_next;
        end
    end

    pkf_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (v6_reg),
        .in_stage  (dv_reg),
        .out_valid (dq_v),
        .out_stage (dq)
    );

    // multiply stage: k settled, point and derivative scaled
    always_comb begin
        logic [31:0]        k;
        logic [32:0]        m;
        logic signed [64:0] pr;
        logic               ksat;
        // a quotient of 2^32 or more clips to the top of the k range
        ksat = dq.kmax | dq.quo[pkf_pkg::QBITS-1];
        k = ksat ? 32'hFFFF_FFFF : dq.quo[31:0];
        if (k < pkf_pkg::KONE) begin
            k = pkf_pkg::KONE;
        end
        pp_next     = dq.pt;
        pp_next.sat = dq.pt.sat | ksat;
        for (int i = 0; i < 3; i++) begin
            pr = $signed({{33{dq.pt.c[i][31]}}, dq.pt.c[i]}) * $signed({33'd0, k});
            pr_next[i] = pr[63:0];
        end
        m       = {1'b0, k} + {9'd0, dep_reg[31:16], 8'd0};
        dm_next = {33'd0, dq.pt.de} * {32'd0, m};
    end

    // output stage: negate, offset, derivative saturation
    always_comb begin
        logic signed [63:0] sh;
        logic signed [47:0] ng, o, sm;
        logic [32:0]        s1, s2;
        logic               sat;
        logic [44:0]        d;
        sat = pp_reg.sat;
        for (int i = 0; i < 3; i++) begin
            sh  = $signed(pr_reg[i]) >>> 20;
            ng  = -sh[47:0];
            s1  = pkf_pkg::sat32(ng);
            o   = $signed({{24{off_reg[16*i+15]}}, off_reg[16*i +: 16], 8'd0});
            sm  = pkf_pkg::sx48(s1[31:0]) + o;
            s2  = pkf_pkg::sat32(sm);
            sat = sat | s1[32] | s2[32];
            case (i)
                0:       out_next.new_x = s2[31:0];
                1:       out_next.new_y = s2[31:0];
                default: out_next.new_z = s2[31:0];
            endcase
        end
        d = dm_reg[64:20];
        if (|d[44:32]) begin
            out_next.deriv_out = 32'hFFFF_FFFF;
            sat = 1'b1;
        end else begin
            out_next.deriv_out = d[31:0];
        end
        out_next.pseudo_de = dep_reg[47:32];
        out_next.saturated = sat;
    end

    assign m_valid = vo_reg;
    assign m_data  = out_reg;

    // the input side only stalls behind a waiting output word
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == !(m_valid && !m_ready))
        else $error("input ready out of step with output stall");

    // a saturated inversion factor must mark the point
    a_kmax: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && dq_v && dq.kmax |=> pp_reg.sat)
        else $error("k saturation lost");

    // nothing leaves right after reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule
`default_nettype wire
